@@ hdl/rme_pkg.sv @@
// Shared constants for the rotation-matrix Euler integrator.
// Field widths, fixed-point scaling and the digit-serial multiplier sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

  // Field widths
  localparam int DT_W   = 24;
  localparam int ACC_W  = 24;
  localparam int MAT_W  = 24;
  localparam int RATE_W = 32;

  // Fixed-point scaling: dt carries 24 fraction bits, R*w drops 16 bits
  localparam int DT_FRAC = 24;
  localparam int RD_FRAC = 16;

  // Matrix value of 1.0 (LSB 2^-20)
  localparam logic signed [MAT_W-1:0] MAT_ONE = 24'sd1048576;

  // Digit-serial multiplier: parallel multiplicand, serial multiplier operand
  localparam int DIG      = 4;
  localparam int MUL_MW   = 28;
  localparam int MUL_NDIG = MUL_MW / DIG;
  localparam int MUL_CW   = $clog2(MUL_NDIG);
  localparam int MCAND_W  = 41;
  localparam int PROD_W   = MCAND_W + MUL_MW;

  // Derivative entry width: sum of two R*w products, before and after rounding
  localparam int DSUM_W = 57;
  localparam int RD_W   = DSUM_W - RD_FRAC;

endpackage

`default_nettype wire

@@ hdl/rme_if.sv @@
// Valid/ready channel interfaces of the rotation-matrix Euler integrator.
// Depends on rme_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rme_in_if;
  logic                              valid;
  logic                              ready;
  logic        [rme_pkg::DT_W-1:0]   time_step;
  logic signed [rme_pkg::ACC_W-1:0]  accel_x;
  logic signed [rme_pkg::ACC_W-1:0]  accel_y;
  logic signed [rme_pkg::ACC_W-1:0]  accel_z;

  modport source (output valid, time_step, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, time_step, accel_x, accel_y, accel_z, output ready);
endinterface

interface rme_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rme_pkg::MAT_W-1:0]  m00;
  logic signed [rme_pkg::MAT_W-1:0]  m01;
  logic signed [rme_pkg::MAT_W-1:0]  m02;
  logic signed [rme_pkg::MAT_W-1:0]  m10;
  logic signed [rme_pkg::MAT_W-1:0]  m11;
  logic signed [rme_pkg::MAT_W-1:0]  m12;
  logic signed [rme_pkg::MAT_W-1:0]  m20;
  logic signed [rme_pkg::MAT_W-1:0]  m21;
  logic signed [rme_pkg::MAT_W-1:0]  m22;
  logic signed [rme_pkg::RATE_W-1:0] rate_x;
  logic signed [rme_pkg::RATE_W-1:0] rate_y;
  logic signed [rme_pkg::RATE_W-1:0] rate_z;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  rate_x, rate_y, rate_z, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  rate_x, rate_y, rate_z, output ready);
endinterface

`default_nettype wire

@@ hdl/rme_dsmul.sv @@
// Digit-serial signed multiplier, one 4-bit digit of the multiplier per cycle.
// Depends on rme_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module rme_dsmul (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [rme_pkg::MCAND_W-1:0]  mcand,
  input  wire logic signed [rme_pkg::MUL_MW-1:0]   mult,
  output logic                                     done,
  output logic signed [rme_pkg::PROD_W-1:0]        product
);

  localparam int PW = rme_pkg::MCAND_W + rme_pkg::DIG + 1;

  logic                               busy;
  logic [rme_pkg::MUL_CW-1:0]         cnt;
  logic signed [rme_pkg::MCAND_W-1:0] mc;
  logic [rme_pkg::MUL_MW-1:0]         mreg;
  logic [rme_pkg::MUL_MW-1:0]         lo;
  logic signed [PW-1:0]               pacc;
  logic signed [PW-1:0]               pp;
  logic signed [PW-1:0]               sum;
  logic signed [rme_pkg::DIG:0]       dsig;
  logic                               last;

  always_comb begin
    last = (cnt == rme_pkg::MUL_CW'(rme_pkg::MUL_NDIG - 1));
    // top digit carries the sign of the multiplier
    dsig = last ? $signed({mreg[rme_pkg::DIG-1], mreg[rme_pkg::DIG-1:0]})
                : $signed({1'b0, mreg[rme_pkg::DIG-1:0]});
    pp   = mc * dsig;
    sum  = pacc + pp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc   <= mcand;
      mreg <= mult;
      pacc <= '0;
      lo   <= '0;
    end else if (busy) begin
      pacc <= sum >>> rme_pkg::DIG;
      lo   <= {sum[rme_pkg::DIG-1:0], lo[rme_pkg::MUL_MW-1:rme_pkg::DIG]};
      mreg <= mreg >> rme_pkg::DIG;
    end
  end

  assign product = $signed({pacc[rme_pkg::MCAND_W-1:0], lo});

endmodule

`default_nettype wire

@@ hdl/rotation_matrix_euler_integrator_top.sv @@
// Top level of the rotation-matrix Euler integrator: sequencer, state stores,
// output register. Depends on rme_pkg, rme_if.sv and rme_dsmul.
//
// Each transfer on req brings a time step dt and an angular acceleration a.
// The block updates its stored rate w' = sat32(w + round(dt*a)), forms
// Rdot = R * skew(w') from the stored 3x3 matrix, steps R' = sat24(R +
// round(dt*Rdot)), stores both and presents one result on rsp. After reset
// the rate is zero and the matrix is the identity. All products run through
// one shared digit-serial multiplier that retires four multiplier bits per
// cycle; an item needs 30 products (3 rate, 18 derivative, 9 matrix). A new
// item is taken only after the previous one has been loaded into the output
// register. The result sits in its own register, so the next item is
// accepted while the previous result waits.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_euler_integrator_top (
  input wire logic clk,
  input wire logic rst,
  rme_in_if.sink   req,
  rme_out_if.source rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic STG_RATE = 1'b0;
  localparam logic STG_ROW  = 1'b1;

  localparam logic [3:0] OP_LAST_RATE = 4'd2;
  localparam logic [3:0] OP_FIRST_UPD = 4'd6;
  localparam logic [3:0] OP_LAST_ROW  = 4'd8;
  localparam logic [1:0] ROW_LAST     = 2'd2;

  localparam int MW  = rme_pkg::MAT_W;
  localparam int RW  = rme_pkg::RATE_W;
  localparam int PW  = rme_pkg::PROD_W;
  localparam int MCW = rme_pkg::MCAND_W;
  localparam int QW  = PW - rme_pkg::DT_FRAC;
  localparam int DW  = rme_pkg::DSUM_W;

  localparam logic signed [PW-1:0] HALF_DT = PW'(1) << (rme_pkg::DT_FRAC - 1);
  localparam logic signed [DW-1:0] HALF_RD = DW'(1) << (rme_pkg::RD_FRAC - 1);

  // Control
  logic [1:0] state;
  logic       stg;
  logic [3:0] cnt;
  logic [1:0] row;

  // Stores and item registers
  logic signed [RW-1:0]  rate [3];
  logic signed [MW-1:0]  mat  [9];
  logic [rme_pkg::DT_W-1:0]         dt;
  logic signed [rme_pkg::ACC_W-1:0] acc [3];
  logic signed [DW-1:0]  term;
  logic signed [rme_pkg::RD_W-1:0] rd [3];

  // Output register
  logic                 out_valid;
  logic signed [MW-1:0] out_mat  [9];
  logic signed [RW-1:0] out_rate [3];

  // Multiplier hookup
  logic                            mul_start;
  logic                            mul_done;
  logic signed [MCW-1:0]           mcand;
  logic signed [rme_pkg::MUL_MW-1:0] mult;
  logic signed [PW-1:0]            product;

  // Decode and datapath
  logic                   is_upd;
  logic [1:0]             dcol;
  logic                   tsel;
  logic [1:0]             col;
  logic [1:0]             col_d;
  logic [1:0]             upd_col;
  logic [1:0]             widx;
  logic [1:0]             rate_idx;
  logic [3:0]             mat_idx;
  logic signed [RW-1:0]   rate_rd;
  logic signed [MW-1:0]   mat_rd;
  logic signed [MCW-1:0]  w_ext;
  logic signed [PW-1:0]   prod_rnd;
  logic signed [QW-1:0]   q_dt;
  logic signed [RW+1:0]   rate_sum;
  logic signed [RW-1:0]   rate_new;
  logic signed [DW-1:0]   dsum;
  logic signed [MW+17:0]  mat_sum;
  logic signed [MW-1:0]   mat_new;
  logic                   out_free;

  rme_dsmul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mult    (mult),
    .done    (mul_done),
    .product (product)
  );

  // Select the operands and the store entries for the current product.
  always_comb begin
    is_upd  = (stg == STG_ROW) && (cnt >= OP_FIRST_UPD);
    dcol    = cnt[2:1];
    tsel    = cnt[0];
    upd_col = 2'(cnt - OP_FIRST_UPD);
    // rd[c] = R[r][c+1]*w[c+2] - R[r][c+2]*w[c+1], indices mod 3
    case (dcol)
      2'd0: begin
        col_d = tsel ? 2'd2 : 2'd1;
        widx  = tsel ? 2'd1 : 2'd2;
      end
      2'd1: begin
        col_d = tsel ? 2'd0 : 2'd2;
        widx  = tsel ? 2'd2 : 2'd0;
      end
      2'd2: begin
        col_d = tsel ? 2'd1 : 2'd0;
        widx  = tsel ? 2'd0 : 2'd1;
      end
      default: begin
        col_d = 2'd0;
        widx  = 2'd0;
      end
    endcase
    col      = is_upd ? upd_col : col_d;
    rate_idx = (stg == STG_RATE) ? cnt[1:0] : widx;
    mat_idx  = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    rate_rd  = rate[rate_idx];
    mat_rd   = mat[mat_idx];
    w_ext    = MCW'(rate_rd);

    if (stg == STG_RATE) begin
      mcand = MCW'(acc[cnt[1:0]]);
      mult  = $signed({{(rme_pkg::MUL_MW - rme_pkg::DT_W){1'b0}}, dt});
    end else if (is_upd) begin
      mcand = MCW'(rd[upd_col]);
      mult  = $signed({{(rme_pkg::MUL_MW - rme_pkg::DT_W){1'b0}}, dt});
    end else begin
      // second product of each pair enters negated, so the pair simply adds
      mcand = tsel ? -w_ext : w_ext;
      mult  = rme_pkg::MUL_MW'(mat_rd);
    end
    mul_start = (state == S_START);
  end

  // Round the finished product and saturate it into the stores.
  always_comb begin
    prod_rnd = product + HALF_DT;
    q_dt     = prod_rnd[PW-1:rme_pkg::DT_FRAC];

    rate_sum = (RW+2)'(rate_rd) + $signed(q_dt[RW+1:0]);
    if (rate_sum[RW+1:RW-1] == 3'b000 || rate_sum[RW+1:RW-1] == 3'b111) begin
      rate_new = rate_sum[RW-1:0];
    end else begin
      rate_new = rate_sum[RW+1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    end

    dsum = term + product[DW-1:0] + HALF_RD;

    mat_sum = (MW+18)'(mat_rd) + $signed(q_dt[MW+17:0]);
    if (mat_sum[MW+17:MW-1] == '0 || mat_sum[MW+17:MW-1] == '1) begin
      mat_new = mat_sum[MW-1:0];
    end else begin
      mat_new = mat_sum[MW+17] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
    end

    out_free = !out_valid || rsp.ready;
  end

  // Sequencer: three rate products, then per row six derivative and three
  // matrix products. Each row of Rdot needs only that row of R, so the row
  // is rewritten in place once its derivatives are held.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stg   <= STG_RATE;
      cnt   <= '0;
      row   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_START;
            stg   <= STG_RATE;
            cnt   <= '0;
            row   <= '0;
          end
        end
        S_START: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (mul_done) begin
            state <= S_START;
            if (stg == STG_RATE) begin
              if (cnt == OP_LAST_RATE) begin
                stg <= STG_ROW;
                cnt <= '0;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end else if (cnt == OP_LAST_ROW) begin
              cnt <= '0;
              if (row == ROW_LAST) begin
                state <= S_OUT;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Rate and matrix stores: reset to zero rate and identity matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        rate[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        mat[i] <= (i % 4 == 0) ? rme_pkg::MAT_ONE : '0;
      end
    end else if (state == S_RUN && mul_done) begin
      if (stg == STG_RATE) begin
        rate[cnt[1:0]] <= rate_new;
      end else if (is_upd) begin
        mat[mat_idx] <= mat_new;
      end
    end
  end

  // Item registers and derivative holding registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      dt     <= req.time_step;
      acc[0] <= req.accel_x;
      acc[1] <= req.accel_y;
      acc[2] <= req.accel_z;
    end
    if (state == S_RUN && mul_done && stg == STG_ROW && !is_upd) begin
      if (!tsel) begin
        term <= product[DW-1:0];
      end else begin
        rd[dcol] <= dsum[DW-1:rme_pkg::RD_FRAC];
      end
    end
  end

  // Output register: load the finished stores, hold until the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_mat  <= mat;
      out_rate <= rate;
    end
  end

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.m00    = out_mat[0];
  assign rsp.m01    = out_mat[1];
  assign rsp.m02    = out_mat[2];
  assign rsp.m10    = out_mat[3];
  assign rsp.m11    = out_mat[4];
  assign rsp.m12    = out_mat[5];
  assign rsp.m20    = out_mat[6];
  assign rsp.m21    = out_mat[7];
  assign rsp.m22    = out_mat[8];
  assign rsp.rate_x = out_rate[0];
  assign rsp.rate_y = out_rate[1];
  assign rsp.rate_z = out_rate[2];

endmodule

`default_nettype wire
